FILE: hw/rtl/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared types and codes for the binary trie longest-prefix match block.
// ----------------------------------------------------------------------------
package btlpm_pkg;

  // request type field
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // result status field
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  // command kinds after classification
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] net_id;
  } in_word_t;

  typedef struct packed {
    logic [15:0] result_net;
    logic        found;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] net_id;
  } cmd_t;

endpackage

FILE: hw/rtl/btlpm_front.sv
// ----------------------------------------------------------------------------
// btlpm_front
// Takes request words and classifies them into lookup, insert or reject.
// ----------------------------------------------------------------------------
module btlpm_front (
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  btlpm_pkg::in_word_t in_data,
  output logic              push,
  output btlpm_pkg::cmd_t   cmd,
  input  logic              full
);
  import btlpm_pkg::*;

  logic [1:0] kind;

  always_comb begin
    if (in_data.req_type == REQ_LOOKUP) begin
      kind = KIND_LOOKUP;
    end else if (in_data.prefix_len > MAX_PREFIX_LEN) begin
      kind = KIND_REJECT;
    end else begin
      kind = KIND_INSERT;
    end
  end

  assign in_stall = full | rst;
  assign push     = in_valid & ~in_stall;

  assign cmd.kind       = kind;
  assign cmd.address    = in_data.address;
  assign cmd.prefix_len = in_data.prefix_len;
  assign cmd.net_id     = in_data.net_id;

endmodule

FILE: hw/rtl/btlpm_queue.sv
// ----------------------------------------------------------------------------
// btlpm_queue
// Short command queue that decouples the front from the trie engine.
// ----------------------------------------------------------------------------
module btlpm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  btlpm_pkg::cmd_t  push_data,
  output logic             full,
  input  logic             pop,
  output btlpm_pkg::cmd_t  pop_data,
  output logic             avail
);
  import btlpm_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]       count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/btlpm_engine.sv
// ----------------------------------------------------------------------------
// btlpm_engine
// Trie walker: node pool memory, root registers, allocator and result word.
// ----------------------------------------------------------------------------
module btlpm_engine #(
  parameter int NODE_COUNT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_avail,
  input  btlpm_pkg::cmd_t      cmd_in,
  output logic                 pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output btlpm_pkg::out_word_t out_data
);
  import btlpm_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  typedef struct packed {
    logic          mark;
    logic [15:0]   id;
    logic [IW-1:0] c0;
    logic [IW-1:0] c1;
  } node_t;

  // node 0 (root) lives in flops; the memory slot 0 is never used
  node_t mem [NODE_COUNT];
  node_t rdata;
  node_t root;

  logic          state;
  cmd_t          cmd;
  logic [5:0]    depth;
  logic [IW-1:0] node;
  logic          at_root;
  logic          fresh;
  logic          hit;
  logic [15:0]   best;
  logic [IW:0]   next_free;
  logic [15:0]   no_match;

  node_t         cur;
  node_t         upd;
  logic          dir;
  logic [IW-1:0] child;
  logic          hit_now;
  logic [15:0]   best_now;
  logic          pool_full;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  node_t         mem_wdata;
  logic [IW-1:0] raddr;
  logic          root_we;
  node_t         root_wdata;

  logic          descend;
  logic          alloc;
  logic          finish;
  out_word_t     result;

  assign cfg_ready = 1'b1;
  assign pop       = (state == S_IDLE) & cmd_avail & ~out_valid;

  // current node: root flops, a just-allocated (cleared) node, or last read
  always_comb begin
    if (at_root) begin
      cur = root;
    end else if (fresh) begin
      cur = '0;
    end else begin
      cur = rdata;
    end
  end

  assign dir       = cmd.address[~depth[4:0]];
  assign child     = dir ? cur.c1 : cur.c0;
  assign hit_now   = hit | cur.mark;
  assign best_now  = cur.mark ? cur.id : best;
  assign pool_full = (next_free >= (IW+1)'(NODE_COUNT));

  always_comb begin
    upd = cur;
    if (dir) begin
      upd.c1 = next_free[IW-1:0];
    end else begin
      upd.c0 = next_free[IW-1:0];
    end
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = node;
    mem_wdata  = '0;
    root_we    = 1'b0;
    root_wdata = root;
    raddr      = child;
    descend    = 1'b0;
    alloc      = 1'b0;
    finish     = 1'b0;
    result     = '0;
    if (state == S_WALK) begin
      if (cmd.kind == KIND_LOOKUP) begin
        if (depth != MAX_PREFIX_LEN && child != '0) begin
          descend = 1'b1;
        end else begin
          finish            = 1'b1;
          result.result_net = best_now;
          result.found      = hit_now;
          result.status     = ST_OK;
        end
      end else begin
        if (depth == cmd.prefix_len) begin
          // mark the final node
          finish = 1'b1;
          if (at_root) begin
            root_we         = 1'b1;
            root_wdata      = cur;
            root_wdata.mark = 1'b1;
            root_wdata.id   = cmd.net_id;
          end else begin
            mem_we         = 1'b1;
            mem_wdata      = cur;
            mem_wdata.mark = 1'b1;
            mem_wdata.id   = cmd.net_id;
          end
        end else if (child != '0) begin
          descend = 1'b1;
        end else if (pool_full) begin
          // a linked node that was just allocated still needs its cleared word
          finish        = 1'b1;
          result.status = ST_FULL;
          mem_we        = fresh;
        end else begin
          alloc = 1'b1;
          if (at_root) begin
            root_we    = 1'b1;
            root_wdata = upd;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = upd;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd     <= cmd_in;
      depth   <= '0;
      node    <= '0;
      at_root <= 1'b1;
      fresh   <= 1'b0;
      hit     <= 1'b0;
      best    <= no_match;
    end else if (state == S_WALK) begin
      hit  <= hit_now;
      best <= best_now;
      if (descend) begin
        node    <= child;
        at_root <= 1'b0;
        fresh   <= 1'b0;
        depth   <= depth + 1'b1;
      end else if (alloc) begin
        node    <= next_free[IW-1:0];
        at_root <= 1'b0;
        fresh   <= 1'b1;
        depth   <= depth + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      root      <= '0;
      next_free <= (IW+1)'(1);
      no_match  <= 16'hFFFF;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        no_match <= cfg_data;
      end
      if (root_we) begin
        root <= root_wdata;
      end
      if (alloc) begin
        next_free <= next_free + 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (cmd_in.kind == KIND_REJECT) begin
              out_valid           <= 1'b1;
              out_data.result_net <= '0;
              out_data.found      <= 1'b0;
              out_data.status     <= ST_LEN;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (finish) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/binary_trie_longest_prefix_match_top.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_top
// IPv4 longest-prefix match over a one-bit-per-level trie in a node pool.
//
//   channel  signals                      word
//   in       in_valid  in_stall  in_data  req_type, address, prefix_len, net_id
//   out      out_valid out_stall out_data result_net, found, status
//   cfg      cfg_valid cfg_ready cfg_data no_match_value (always ready)
//
// A word passes through the queue, then the engine visits the trie levels one
// by one (one synchronous node-memory read each), up to 33 nodes for a full
// 32-bit walk; a rejected length skips the walk. The next command starts the
// cycle after the result word is taken, and a two-word queue keeps taking
// words meanwhile.
// Reset clears the root in flops; the pool needs no clearing pass.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_top #(
  parameter int NODE_COUNT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  btlpm_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output btlpm_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import btlpm_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t pop_cmd;
  logic avail;

  btlpm_front u_front (
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .cmd      (push_cmd),
    .full     (full)
  );

  btlpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .avail     (avail)
  );

  btlpm_engine #(
    .NODE_COUNT (NODE_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (avail),
    .cmd_in    (pop_cmd),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the trie longest-prefix match block. Requests are
// driven with random gaps, and results are taken with random stalls. A trie
// model inside the bench predicts every result word. It covers lookups, inserts,
// rejected lengths, the default route, re-inserts and pool exhaustion, over
// several no-match settings.
// ----------------------------------------------------------------------------
module tb;
  import btlpm_pkg::*;

  localparam int NODES         = 4096;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no word moving on any channel
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  binary_trie_longest_prefix_match_top #(.NODE_COUNT(NODES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trie model: node pool with a bump allocator, plus the queue of result
  // words still owed by the block.
  class lpm_predictor;
    bit          marked [NODES];
    logic [15:0] net_of [NODES];
    int unsigned child  [NODES][2];
    int unsigned next_free;
    logic [15:0] miss_id;
    out_word_t   expected_words[$];
    int          errors;

    function new();
      foreach (marked[i]) begin
        marked[i]   = 1'b0;
        net_of[i]   = '0;
        child[i][0] = 0;
        child[i][1] = 0;
      end
      next_free = 1;
      miss_id   = 16'hFFFF;
      errors    = 0;
    endfunction

    function void set_no_match(logic [15:0] v);
      miss_id = v;
    endfunction

    function int free_nodes();
      return NODES - int'(next_free);
    endfunction

    function void note_request(in_word_t w);
      out_word_t   r;
      int unsigned node;
      int unsigned nxt;
      bit          b;
      bit          full;
      r    = '0;
      node = 0;
      full = 1'b0;
      r.status = ST_OK;
      if (w.req_type == REQ_LOOKUP) begin
        r.result_net = miss_id;
        if (marked[0]) begin
          r.found      = 1'b1;
          r.result_net = net_of[0];
        end
        for (int d = 0; d < 32; d++) begin
          b   = w.address[31 - d];
          nxt = child[node][b];
          if (nxt == 0) break;
          node = nxt;
          if (marked[node]) begin
            r.found      = 1'b1;
            r.result_net = net_of[node];
          end
        end
      end else if (w.prefix_len > MAX_PREFIX_LEN) begin
        r.status = ST_LEN;
      end else begin
        for (int d = 0; d < int'(w.prefix_len); d++) begin
          b   = w.address[31 - d];
          nxt = child[node][b];
          if (nxt == 0) begin
            // nodes taken before running dry stay linked
            if (next_free >= NODES) begin
              full = 1'b1;
              break;
            end
            nxt = next_free;
            next_free++;
            marked[nxt]   = 1'b0;
            net_of[nxt]   = '0;
            child[nxt][0] = 0;
            child[nxt][1] = 0;
            child[node][b] = nxt;
          end
          node = nxt;
        end
        if (full) begin
          r.status = ST_FULL;
        end else begin
          marked[node] = 1'b1;
          net_of[node] = w.net_id;
        end
      end
      expected_words.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", got));
      end else begin
        want = expected_words.pop_front();
        if (got.result_net !== want.result_net)
          report_mismatch($sformatf("result_net %h, want %h", got.result_net, want.result_net));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      end
    endtask
  endclass

  lpm_predictor routes;
  bit           quiet = 1'b0;   // no random gaps or random stalls while set
  int           holds_asked = 0;
  int           holds_served = 0;
  int           hold_left = 0;
  int           stall_left = 0;
  int           idle_count = 0;
  logic [31:0]  bases[8];
  logic [31:0]  known_addr[$];
  int           known_len[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] prefix_mask(int len);
    logic [63:0] m;
    m = ~64'd0 << (32 - len);
    return m[31:0];
  endfunction

  // Mostly lookups near stored prefixes and inserts that branch off a few
  // base routes near the end of the prefix, so the pool lasts; the rest is
  // noise: bad lengths and fully random addresses.
  function automatic in_word_t next_random_request(bit allow_root);
    in_word_t w;
    int       r;
    int       idx;
    int       len;
    int       lo;
    w.address    = $urandom;
    w.prefix_len = 6'($urandom);
    w.net_id     = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      w.req_type = REQ_LOOKUP;
      if (known_addr.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, known_addr.size() - 1);
        w.address = (known_addr[idx] & prefix_mask(known_len[idx]))
                  | (w.address & ~prefix_mask(known_len[idx]));
      end
    end else if (r < 90) begin
      w.req_type = REQ_INSERT;
      if (allow_root && $urandom_range(0, 19) == 0) len = 0;
      else if ($urandom_range(0, 3) == 0) len = 8 * $urandom_range(1, 4);
      else len = $urandom_range(1, 32);
      if (len != 0 && $urandom_range(0, 9) != 0) begin
        w.address = bases[$urandom_range(0, 7)] ^ (w.address & ~prefix_mask(len));
        if ($urandom_range(0, 4) != 0) begin
          lo = (len > 6) ? len - 6 : 0;
          w.address ^= 32'h8000_0000 >> $urandom_range(lo, len - 1);
        end
      end
      w.prefix_len = 6'(len);
      known_addr.push_back(w.address);
      known_len.push_back(len);
    end else begin
      w.req_type   = REQ_INSERT;
      w.prefix_len = 6'($urandom_range(33, 63));
    end
    return w;
  endfunction

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with valid still high.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_req(logic req, logic [31:0] addr, logic [5:0] len, logic [15:0] nid);
    in_word_t w;
    w.req_type   = req;
    w.address    = addr;
    w.prefix_len = len;
    w.net_id     = nid;
    send_word(w);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    while (routes.expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_no_match(logic [15:0] v);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    routes.set_no_match(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (holds_asked != holds_served) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      holds_served++;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // words are taken at the rising edge; a long stretch with no word moving
  // on any channel ends the run
  always @(posedge clk) begin
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        routes.note_request(in_data);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        routes.check_result(out_data);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      idle_count = moved ? 0 : idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int guard;
    routes = new();
    foreach (bases[i]) bases[i] = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: misses, bad lengths, nesting, full depth, id equal to the
    // no-match value, overwrite
    write_no_match(16'h0000);
    send_req(REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_req(REQ_INSERT, 32'h0A00_0000, 6'd33, 16'h1111);
    send_req(REQ_INSERT, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_req(REQ_INSERT, 32'h0A00_0000, 6'd8, 16'h0A00);
    send_req(REQ_INSERT, 32'h0A01_0000, 6'd16, 16'h0A01);
    send_req(REQ_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0000);
    send_req(REQ_LOOKUP, 32'h0A02_0304, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'h0000_0000, 6'd32, 16'h0000);
    send_req(REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_req(REQ_LOOKUP, 32'h0000_0001, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'h0A00_0000, 6'd8, 16'h1234);
    send_req(REQ_LOOKUP, 32'h0A09_0909, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'h8000_0000, 6'd1, 16'h5555);
    send_req(REQ_LOOKUP, 32'hC000_0000, 6'd0, 16'h0000);
    send_req(REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'hAAAA_AAAA, 6'd32, 16'hAAAA);
    send_req(REQ_LOOKUP, 32'hAAAA_AAAA, 6'd0, 16'h0000);
    send_req(REQ_LOOKUP, 32'hAAAA_AAAB, 6'd0, 16'h0000);
    end_burst();

    write_no_match(16'hFFFF);
    repeat (550) send_word(next_random_request(1'b0));
    end_burst();

    // back-to-back traffic while the receiver holds off, so the input backs up
    write_no_match(16'($urandom_range(1, 16'hFFFE)));
    quiet = 1'b1;
    holds_asked++;
    repeat (450) send_word(next_random_request(1'b0));
    quiet = 1'b0;
    end_burst();

    // default route: first a miss, then a root id equal to the no-match value
    write_no_match(16'h8001);
    send_req(REQ_LOOKUP, 32'h5A5A_5A5A, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'hFFFF_FFFF, 6'd0, 16'h8001);
    send_req(REQ_LOOKUP, 32'h5A5A_5A5A, 6'd0, 16'h0000);
    send_req(REQ_INSERT, 32'h0000_0000, 6'd0, 16'hD0D0);
    send_req(REQ_LOOKUP, 32'h5A5A_5A5A, 6'd0, 16'h0000);
    send_req(REQ_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0000);

    // run the pool dry with fresh full-length routes, then keep going
    guard = 0;
    while (routes.free_nodes() > 0 && guard < 600) begin
      send_req(REQ_INSERT, $urandom, 6'd32, 16'($urandom));
      guard++;
    end
    repeat (10) send_req(REQ_INSERT, $urandom, 6'd32, 16'($urandom));
    repeat (450) send_word(next_random_request(1'b1));
    end_burst();

    repeat (50) @(posedge clk);
    if (routes.expected_words.size() != 0)
      routes.report_mismatch($sformatf("%0d results never arrived",
                                       routes.expected_words.size()));
    if (routes.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
